/* rtl/core/assert_macros.svh */
// ============================================================================
// Assertion macros
// Concurrent assertion wrappers used by rdc_back. They compile to nothing
// when SYNTHESIS is defined.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant check failed");

`else

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)

`define ASSERT_ALWAYS(lbl, clk, rst, cond)

`endif

`endif

/* rtl/core/rdc_pkg.sv */
// ============================================================================
// rdc_pkg
// Shared constants, types and helpers of the radix digit converter.
// ============================================================================
package rdc_pkg;

   localparam int DEFAULT_VALUE_WIDTH = 32;
   localparam int DEFAULT_MAX_DIGITS  = 32;

   localparam int VALUE_IN_W = 32;   // width of the value port
   localparam int RADIX_W    = 9;
   localparam int DIGIT_W    = 8;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 9'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 9'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 9'd256;

   // quotient bits resolved per divider cycle
   localparam int BITS_PER_CYCLE = 4;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_EMIT = 3'b100
   } back_state_type;

   function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
      if (r < RADIX_MIN) begin
         return RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         return RADIX_MAX;
      end else begin
         return r;
      end
   endfunction

endpackage

/* rtl/core/radix_digit_converter.sv */
// ============================================================================
// radix_digit_converter
// Writes an unsigned integer as digits in a programmable radix.
// ============================================================================
// Usage:
//   req_valid/req_ready/req_value take one unsigned value per item.
//   rsp_valid/rsp_ready return its digits, most significant first, one item
//   per digit; rsp_last_digit marks the least significant digit. Zero gives
//   the single digit 0.
//   csr_wr_en/csr_wr_data write the radix (2..256, reset 10; lower values act
//   as 2, higher as 256). Write it only while no conversion is in flight.
// Timing:
//   4 quotient bits per divider cycle; each digit takes a full division of the
//   W-bit value, padded to a multiple of 4 bits. With an open receiver the
//   digits leave one per cycle; the next item is dequeued only once the back
//   end has moved the last digit of the current item to its output register.
//   Reset empties the two-entry queue, idles the back end, sets the radix to 10.
//   A stall holds the digit and the back end; only a held last digit lets the
//   next item start dividing. Input is refused only when the queue is full.
// ============================================================================
module radix_digit_converter #(
   parameter int VALUE_WIDTH = rdc_pkg::DEFAULT_VALUE_WIDTH,
   parameter int MAX_DIGITS  = rdc_pkg::DEFAULT_MAX_DIGITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rdc_pkg::VALUE_IN_W-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rdc_pkg::DIGIT_W-1:0]   rsp_digit,
   output logic                          rsp_last_digit,
   input  logic                          csr_wr_en,
   input  logic [rdc_pkg::RADIX_W-1:0]   csr_wr_data
);
   import rdc_pkg::*;

   localparam int CONV_W = (VALUE_WIDTH < VALUE_IN_W) ? VALUE_WIDTH : VALUE_IN_W;

   logic               q_valid;
   logic               q_ready;
   logic [CONV_W-1:0]  q_value;
   logic [RADIX_W-1:0] q_radix;

   rdc_front #(
      .CONV_W (CONV_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_value   (req_value),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_value     (q_value),
      .q_radix     (q_radix)
   );

   rdc_back #(
      .CONV_W     (CONV_W),
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_ready        (q_ready),
      .q_value        (q_value),
      .q_radix        (q_radix),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit      (rsp_digit),
      .rsp_last_digit (rsp_last_digit)
   );

endmodule

/* rtl/core/rdc_front.sv */
// ============================================================================
// rdc_front
// Holds the radix register, trims incoming items and queues them for the
// conversion back end.
// ============================================================================
module rdc_front #(
   parameter int CONV_W = rdc_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [rdc_pkg::VALUE_IN_W-1:0]    req_value,
   input  logic                              csr_wr_en,
   input  logic [rdc_pkg::RADIX_W-1:0]       csr_wr_data,
   output logic                              q_valid,
   input  logic                              q_ready,
   output logic [CONV_W-1:0]                 q_value,
   output logic [rdc_pkg::RADIX_W-1:0]       q_radix
);
   import rdc_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic [CONV_W-1:0]  entry_value_ff [QUEUE_DEPTH];
   logic [RADIX_W-1:0] entry_radix_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign radix_in = csr_wr_en ? csr_wr_data : radix_ff;

   assign req_ready = (count_ff < CNT_W'(QUEUE_DEPTH));
   assign q_valid   = (count_ff != '0);
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   assign q_value = entry_value_ff[rd_ptr_ff];
   assign q_radix = entry_radix_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff  <= RADIX_RESET;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         radix_ff  <= radix_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // item is trimmed to the conversion width, radix clamped to 2..256
   always_ff @(posedge clock) begin
      if (push) begin
         entry_value_ff[wr_ptr_ff] <= req_value[CONV_W-1:0];
         entry_radix_ff[wr_ptr_ff] <= clamp_radix(radix_ff);
      end
   end

endmodule

/* rtl/core/rdc_back.sv */
// ============================================================================
// rdc_back
// Radix divider, digit store and most-significant-first digit emitter.
// ============================================================================
`include "assert_macros.svh"

module rdc_back #(
   parameter int CONV_W     = rdc_pkg::DEFAULT_VALUE_WIDTH,
   parameter int MAX_DIGITS = rdc_pkg::DEFAULT_MAX_DIGITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   output logic                          q_ready,
   input  logic [CONV_W-1:0]             q_value,
   input  logic [rdc_pkg::RADIX_W-1:0]   q_radix,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rdc_pkg::DIGIT_W-1:0]   rsp_digit,
   output logic                          rsp_last_digit
);
   import rdc_pkg::*;

   localparam int PAD_W  = ((CONV_W + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE) * BITS_PER_CYCLE;
   localparam int STEPS  = PAD_W / BITS_PER_CYCLE;
   localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int ADDR_W = $clog2(MAX_DIGITS);

   back_state_type     state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [ADDR_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic               issuing_ff, issuing_in;
   logic               pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RADIX_W-1:0] rem_ff, rem_in;
   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic [PAD_W-1:0]   work_ff, work_in;
   logic [DIGIT_W-1:0] rd_data_ff;
   logic               rd_last_ff;
   logic [DIGIT_W-1:0] rsp_digit_ff;
   logic               rsp_last_ff;
   logic [DIGIT_W-1:0] digit_mem [MAX_DIGITS];

   logic [RADIX_W-1:0] div_rem;
   logic [PAD_W-1:0]   div_work;
   logic               mem_we;
   logic               issue;
   logic               advance;

   // restoring division, BITS_PER_CYCLE quotient bits per cycle;
   // quotient bits shift into the low end of the dividend word
   always_comb begin
      div_rem  = rem_ff;
      div_work = work_ff;
      for (int i = 0; i < BITS_PER_CYCLE; i++) begin
         div_rem  = {div_rem[RADIX_W-2:0], div_work[PAD_W-1]};
         div_work = {div_work[PAD_W-2:0], 1'b0};
         if (div_rem >= radix_ff) begin
            div_rem     = div_rem - radix_ff;
            div_work[0] = 1'b1;
         end
      end
   end

   assign advance = pend_ff && (!rsp_valid_ff || rsp_ready);
   assign issue   = (state_ff == ST_EMIT) && issuing_ff && (!pend_ff || advance);
   assign pend_in = issue || (pend_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   assign q_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cnt_in     = cnt_ff;
      rd_ptr_in  = rd_ptr_ff;
      issuing_in = issuing_ff;
      rem_in     = rem_ff;
      radix_in   = radix_ff;
      work_in    = work_ff;
      mem_we     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               work_in  = PAD_W'(q_value);
               radix_in = q_radix;
               rem_in   = '0;
               step_in  = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = div_rem;
            work_in = div_work;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(STEPS - 1)) begin
               mem_we  = 1'b1;
               step_in = '0;
               rem_in  = '0;
               // stop on a zero quotient or when the store is full
               if (div_work == '0 || cnt_ff == ADDR_W'(MAX_DIGITS - 1)) begin
                  rd_ptr_in  = cnt_ff;
                  issuing_in = 1'b1;
                  state_in   = ST_EMIT;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (issue) begin
               if (rd_ptr_ff == '0) begin
                  issuing_in = 1'b0;
               end else begin
                  rd_ptr_in = rd_ptr_ff - 1'b1;
               end
            end
            if (!issuing_ff && !pend_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         cnt_ff       <= '0;
         rd_ptr_ff    <= '0;
         issuing_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         rd_ptr_ff    <= rd_ptr_in;
         issuing_ff   <= issuing_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      radix_ff <= radix_in;
      work_ff  <= work_in;
   end

   // digit store: digits land least significant first, read back in reverse
   always_ff @(posedge clock) begin
      if (mem_we) begin
         digit_mem[cnt_ff] <= div_rem[DIGIT_W-1:0];
      end
      if (issue) begin
         rd_data_ff <= digit_mem[rd_ptr_ff];
         rd_last_ff <= (rd_ptr_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_digit_ff <= rd_data_ff;
         rsp_last_ff  <= rd_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit      = rsp_digit_ff;
   assign rsp_last_digit = rsp_last_ff;

   `ASSERT_IMPLY(a_rem_below_radix, clock, reset, state_ff == ST_DIV, rem_ff < radix_ff)
   `ASSERT_IMPLY(a_pend_in_emit, clock, reset, pend_ff, state_ff == ST_EMIT)
   `ASSERT_IMPLY(a_issue_in_emit, clock, reset, issuing_ff, state_ff == ST_EMIT)
   `ASSERT_IMPLY(a_radix_legal, clock, reset, state_ff == ST_DIV,
      (radix_ff >= RADIX_MIN) && (radix_ff <= RADIX_MAX))

endmodule
